### design/macp_pkg.sv
// ----------------------------------------------------------------------------
// macp_pkg
// Shared types and character constants for the MAC address text parser.
// ----------------------------------------------------------------------------
package macp_pkg;

    // One input request: a text character or the end-of-string marker
    typedef struct packed {
        logic [7:0] character;
        logic       end_of_string;
    } in_item_t;

    // One result: assembled address, completed part count and valid flag
    typedef struct packed {
        logic [47:0] mac;
        logic [2:0]  parts_parsed;
        logic        valid_res;
    } out_item_t;

    // Character codes
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

    // Part counting
    localparam int         NUM_BYTES   = 6;
    localparam logic [2:0] PART_LIMIT  = 3'd6;
    localparam logic [2:0] COUNT_MAX   = 3'd7;
    localparam logic [1:0] DIGITS_FULL = 2'd2;

endpackage

### design/macp_hex_decode.sv
// ----------------------------------------------------------------------------
// macp_hex_decode
// Decode one text character into a hex nibble and a hex-digit flag.
// ----------------------------------------------------------------------------
module macp_hex_decode (
    input  logic [7:0] character,
    output logic       is_hex,
    output logic [3:0] nibble
);

    logic is_digit;
    logic is_lower;
    logic is_upper;
    logic [7:0] off_digit;
    logic [7:0] off_lower;
    logic [7:0] off_upper;

    // Classify the character range
    assign is_digit = (character >= macp_pkg::CHAR_ZERO)
                   && (character <= macp_pkg::CHAR_NINE);
    assign is_lower = (character >= macp_pkg::CHAR_LOWER_A)
                   && (character <= macp_pkg::CHAR_LOWER_F);
    assign is_upper = (character >= macp_pkg::CHAR_UPPER_A)
                   && (character <= macp_pkg::CHAR_UPPER_F);

    assign off_digit = character - macp_pkg::CHAR_ZERO;
    assign off_lower = character - macp_pkg::CHAR_LOWER_A;
    assign off_upper = character - macp_pkg::CHAR_UPPER_A;

    // Select the nibble value
    always_comb begin
        nibble = 4'd0;
        if (is_digit) begin
            nibble = off_digit[3:0];
        end else if (is_lower) begin
            nibble = off_lower[3:0] + macp_pkg::HEX_LETTER_BASE;
        end else if (is_upper) begin
            nibble = off_upper[3:0] + macp_pkg::HEX_LETTER_BASE;
        end
    end

    assign is_hex = is_digit || is_lower || is_upper;

endmodule

### design/macp_parse_core.sv
// ----------------------------------------------------------------------------
// macp_parse_core
// Parser state and per-request update; forms the result on end of string.
// ----------------------------------------------------------------------------
module macp_parse_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  macp_pkg::in_item_t    item,
    output macp_pkg::out_item_t   result
);

    logic [2:0]  part_count_reg;
    logic [2:0]  part_count_next;
    logic [1:0]  digit_count_reg;
    logic [1:0]  digit_count_next;
    logic [7:0]  part_value_reg;
    logic [7:0]  part_value_next;
    logic [47:0] address_bytes_reg;
    logic [47:0] address_bytes_next;
    logic        stopped_reg;
    logic        stopped_next;

    logic        is_hex;
    logic [3:0]  nibble;
    logic [47:0] addr_closed;
    logic [2:0]  count_closed;

    macp_hex_decode u_hex_decode (
        .character (item.character),
        .is_hex    (is_hex),
        .nibble    (nibble)
    );

    // Close the current part: merge its byte and bump the saturating count
    always_comb begin
        addr_closed = address_bytes_reg;
        for (int i = 0; i < macp_pkg::NUM_BYTES; i++) begin
            if (part_count_reg == 3'(i)) begin
                addr_closed[8*(macp_pkg::NUM_BYTES-1-i) +: 8] =
                    address_bytes_reg[8*(macp_pkg::NUM_BYTES-1-i) +: 8] | part_value_reg;
            end
        end
        count_closed = (part_count_reg == macp_pkg::COUNT_MAX) ? part_count_reg
                                                               : part_count_reg + 3'd1;
    end

    // Result seen on an end-of-string request
    always_comb begin
        result.mac          = stopped_reg ? address_bytes_reg : addr_closed;
        result.parts_parsed = stopped_reg ? part_count_reg : count_closed;
        result.valid_res    = (result.parts_parsed == macp_pkg::PART_LIMIT);
    end

    // Advance the parser state by one request
    always_comb begin
        part_count_next    = part_count_reg;
        digit_count_next   = digit_count_reg;
        part_value_next    = part_value_reg;
        address_bytes_next = address_bytes_reg;
        stopped_next       = stopped_reg;
        if (step) begin
            if (item.end_of_string) begin
                part_count_next    = 3'd0;
                digit_count_next   = 2'd0;
                part_value_next    = 8'd0;
                address_bytes_next = 48'd0;
                stopped_next       = 1'b0;
            end else if (!stopped_reg) begin
                if (item.character == macp_pkg::CHAR_COLON) begin
                    address_bytes_next = addr_closed;
                    part_count_next    = count_closed;
                    digit_count_next   = 2'd0;
                    part_value_next    = 8'd0;
                end else if (digit_count_reg >= macp_pkg::DIGITS_FULL || !is_hex) begin
                    stopped_next = 1'b1;
                end else begin
                    part_value_next  = {part_value_reg[3:0], nibble};
                    digit_count_next = digit_count_reg + 2'd1;
                end
            end
        end
    end

    // Hold the parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_count_reg    <= 3'd0;
            digit_count_reg   <= 2'd0;
            part_value_reg    <= 8'd0;
            address_bytes_reg <= 48'd0;
            stopped_reg       <= 1'b0;
        end else begin
            part_count_reg    <= part_count_next;
            digit_count_reg   <= digit_count_next;
            part_value_reg    <= part_value_next;
            address_bytes_reg <= address_bytes_next;
            stopped_reg       <= stopped_next;
        end
    end

`ifndef SYNTHESIS
    // A part never holds more than two digits
    assert property (@(posedge aclk) disable iff (!aresetn)
        digit_count_reg <= macp_pkg::DIGITS_FULL)
        else $error("digit count beyond two");

    // End of string leaves a clean parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.end_of_string |=>
            part_count_reg == 3'd0 && !stopped_reg && address_bytes_reg == 48'd0)
        else $error("parser not cleared after end of string");

    // No address byte is set before the first part is completed
    assert property (@(posedge aclk) disable iff (!aresetn)
        part_count_reg == 3'd0 |-> address_bytes_reg == 48'd0)
        else $error("address bytes set with no completed part");
`endif

endmodule

### design/mac_address_text_parser_unit.sv
// Path: an accepted request waits in the input register; the parser update
//   then feeds the result register, which drives m_valid on end of string.
// Throughput: one request per cycle, unless an end-of-string request is held
//   while an unread result waits in the result register.
// Reset: synchronous active-low aresetn clears the parser and both valid flags.
// ----------------------------------------------------------------------------
// mac_address_text_parser_unit
// Parse colon-separated MAC address text into a 48-bit address per string.
// ----------------------------------------------------------------------------
module mac_address_text_parser_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  macp_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output macp_pkg::out_item_t   m_data
);

    logic                 in_valid_reg;
    macp_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    macp_pkg::out_item_t  out_item_reg;
    macp_pkg::out_item_t  result;
    logic                 advance;

    // Step the parser unless an end request would overwrite an unread result
    assign advance = in_valid_reg
                  && (!in_item_reg.end_of_string || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    macp_parse_core u_parse_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // Input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.end_of_string) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.end_of_string) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

`ifndef SYNTHESIS
    // Valid flag agrees with the part count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.valid_res == (m_data.parts_parsed == macp_pkg::PART_LIMIT)))
        else $error("valid_res disagrees with parts_parsed");

    // Input side stalls only while a request is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && in_item_reg.end_of_string && out_valid_reg)
        else $error("input stalled without a blocked end request");

    // Hold a stalled result unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result dropped or changed");
`endif

endmodule

### tb/mac_address_text_parser_checker.sv
// ----------------------------------------------------------------------------
// mac_address_text_parser_checker
// Watches both channels of the MAC address text parser, tracks the parse of
// every accepted request and compares each result, field by field, with the
// address expected from the text seen so far.
// ----------------------------------------------------------------------------
module mac_address_text_parser_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  macp_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  macp_pkg::out_item_t m_data,
    output int                  error_count,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow parser state
    logic [2:0]  parts_done;
    logic [1:0]  digits_seen;
    logic [7:0]  part_byte;
    logic [47:0] address_acc;
    logic        parse_halted;

    macp_pkg::out_item_t expected_addresses[$];
    int                  mismatches = 0;

    // Nibble value of a hex character; bit 4 set when the character is not hex
    function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
        logic [7:0] d;
        if (c >= macp_pkg::CHAR_ZERO && c <= macp_pkg::CHAR_NINE) begin
            d = c - macp_pkg::CHAR_ZERO;
        end else if (c >= macp_pkg::CHAR_LOWER_A && c <= macp_pkg::CHAR_LOWER_F) begin
            d = c - macp_pkg::CHAR_LOWER_A + {4'd0, macp_pkg::HEX_LETTER_BASE};
        end else if (c >= macp_pkg::CHAR_UPPER_A && c <= macp_pkg::CHAR_UPPER_F) begin
            d = c - macp_pkg::CHAR_UPPER_A + {4'd0, macp_pkg::HEX_LETTER_BASE};
        end else begin
            d = 8'd16;
        end
        return d[4:0];
    endfunction

    task clear_parser();
        parts_done   = '0;
        digits_seen  = '0;
        part_byte    = '0;
        address_acc  = '0;
        parse_halted = 1'b0;
    endtask

    // Store the current part in its byte slot and start a new one
    task close_current_part();
        int          shift_bits;
        logic [47:0] placed;
        if (parts_done < macp_pkg::PART_LIMIT) begin
            shift_bits  = (macp_pkg::NUM_BYTES - 1 - int'(parts_done)) * 8;
            placed      = {40'd0, part_byte};
            address_acc = address_acc | (placed << shift_bits);
        end
        if (parts_done != macp_pkg::COUNT_MAX) begin
            parts_done = parts_done + 3'd1;
        end
        digits_seen = '0;
        part_byte   = '0;
    endtask

    // Advance the shadow parser by one request; queue a result on end of text
    task parse_request(input macp_pkg::in_item_t req);
        logic [4:0]          nib;
        macp_pkg::out_item_t res;
        if (req.end_of_string) begin
            if (!parse_halted) begin
                close_current_part();
            end
            res.mac          = address_acc;
            res.parts_parsed = parts_done;
            res.valid_res    = (parts_done == macp_pkg::PART_LIMIT);
            expected_addresses.push_back(res);
            clear_parser();
        end else if (!parse_halted) begin
            if (req.character == macp_pkg::CHAR_COLON) begin
                close_current_part();
            end else if (digits_seen >= macp_pkg::DIGITS_FULL) begin
                parse_halted = 1'b1;
            end else begin
                nib = hex_digit_value(req.character);
                if (nib[4]) begin
                    parse_halted = 1'b1;
                end else begin
                    part_byte   = {part_byte[3:0], nib[3:0]};
                    digits_seen = digits_seen + 2'd1;
                end
            end
        end
    endtask

    // Compare accepted results, then track accepted requests
    always @(posedge aclk) begin
        macp_pkg::out_item_t want;
        if (!aresetn) begin
            clear_parser();
            expected_addresses.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_addresses.size() == 0) begin
                    $display("%0t: unexpected result mac=%h parts=%0d valid=%b",
                             $time, m_data.mac, m_data.parts_parsed, m_data.valid_res);
                    mismatches++;
                end else begin
                    want = expected_addresses.pop_front();
                    if (m_data.mac !== want.mac) begin
                        $display("%0t: mac mismatch: expected %h, actual %h",
                                 $time, want.mac, m_data.mac);
                        mismatches++;
                    end
                    if (m_data.parts_parsed !== want.parts_parsed) begin
                        $display("%0t: parts_parsed mismatch: expected %0d, actual %0d",
                                 $time, want.parts_parsed, m_data.parts_parsed);
                        mismatches++;
                    end
                    if (m_data.valid_res !== want.valid_res) begin
                        $display("%0t: valid_res mismatch: expected %b, actual %b",
                                 $time, want.valid_res, m_data.valid_res);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                parse_request(s_data);
            end
        end
        error_count <= mismatches;
        outstanding <= expected_addresses.size();
    end

endmodule

### tb/mac_address_text_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// mac_address_text_parser_unit_tb
// Feeds MAC address text to the parser: a few directed strings for the edge
// cases, then random well-formed, broken and noisy strings under three
// phases of sender and receiver idling. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module mac_address_text_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_REQUESTS = 1750;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_GAP         = 40;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    macp_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    macp_pkg::out_item_t m_data;

    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        sent_requests = 0;
    int        quiet_cycles  = 0;
    int        error_count;
    int        outstanding;

    logic [7:0] text_buf[$];

    always #4 aclk = ~aclk;

    mac_address_text_parser_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mac_address_text_parser_checker parse_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one request, idling first at random; hold valid until accepted
    task send_request(input logic [7:0] ch, input logic eos);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{character: ch, end_of_string: eos};
        do @(posedge aclk); while (!s_ready);
        sent_requests++;
    endtask

    // Send the buffered text, then the end marker with a random character
    task send_text();
        foreach (text_buf[i]) begin
            send_request(text_buf[i], 1'b0);
        end
        send_request(8'($urandom_range(255)), 1'b1);
        text_buf.delete();
    endtask

    function automatic logic [7:0] hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(15));
        if (v < 8'd10) begin
            return macp_pkg::CHAR_ZERO + v;
        end else if ($urandom_range(1) == 0) begin
            return macp_pkg::CHAR_LOWER_A + v - {4'd0, macp_pkg::HEX_LETTER_BASE};
        end else begin
            return macp_pkg::CHAR_UPPER_A + v - {4'd0, macp_pkg::HEX_LETTER_BASE};
        end
    endfunction

    // Build an address text; a broken one gets a stray character in one part
    task build_address(input int n_parts, input logic broken);
        int n_digits;
        int bad_part;
        bad_part = $urandom_range(n_parts - 1);
        for (int p = 0; p < n_parts; p++) begin
            if (p > 0) begin
                text_buf.push_back(macp_pkg::CHAR_COLON);
            end
            n_digits = $urandom_range(9);
            n_digits = (n_digits < 7) ? 2 : (n_digits < 9) ? 1 : 0;
            repeat (n_digits) text_buf.push_back(hex_char());
            if (broken && p == bad_part) begin
                if ($urandom_range(1) == 0) begin
                    text_buf.push_back(hex_char());
                end else begin
                    text_buf.push_back(8'($urandom_range(255)));
                end
            end
        end
    endtask

    task build_noise();
        int sel;
        repeat ($urandom_range(12)) begin
            sel = $urandom_range(9);
            if (sel < 2) begin
                text_buf.push_back(macp_pkg::CHAR_COLON);
            end else if (sel < 4) begin
                text_buf.push_back(hex_char());
            end else begin
                text_buf.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        int kind;
        int n_parts;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty text closes one empty part
        send_request(8'hFF, 1'b1);

        // Mixed case digits, a single-digit part, then a stop on an all-ones byte
        text_buf = '{8'h46, 8'h30, macp_pkg::CHAR_COLON, 8'h61, macp_pkg::CHAR_COLON, 8'hFF};
        send_text();

        // Single digit, then a stop on a zero byte
        text_buf = '{8'h62, macp_pkg::CHAR_COLON, 8'h00};
        send_text();

        // Six empty parts, then a third digit stops parsing: still a full address
        text_buf = '{macp_pkg::CHAR_COLON, macp_pkg::CHAR_COLON, macp_pkg::CHAR_COLON,
                     macp_pkg::CHAR_COLON, macp_pkg::CHAR_COLON, macp_pkg::CHAR_COLON,
                     8'h31, 8'h32, 8'h33};
        send_text();

        // Random strings under three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 24 : 0;
            while (sent_requests < TARGET_REQUESTS * (phase + 1) / 3) begin
                kind    = $urandom_range(99);
                n_parts = ($urandom_range(9) < 6) ? 6 : $urandom_range(1, 9);
                if (kind < 70) begin
                    build_address(n_parts, 1'b0);
                end else if (kind < 85) begin
                    build_address(n_parts, 1'b1);
                end else begin
                    build_noise();
                end
                send_text();
            end
        end
        s_valid <= 1'b0;

        // Drain remaining results
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
design/macp_pkg.sv
design/macp_hex_decode.sv
design/macp_parse_core.sv
design/mac_address_text_parser_unit.sv
tb/mac_address_text_parser_checker.sv
tb/mac_address_text_parser_unit_tb.sv
